// ===== design/siphash_2_4_stream_assert.svh =====
// Assertion macros shared by the SipHash stream modules.
`ifndef SIPHASH_2_4_STREAM_ASSERT_SVH
`define SIPHASH_2_4_STREAM_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define SPH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define SPH_NEVER(lbl, cond, msg) \
    `SPH_ASSERT(lbl, !(cond), msg)

`endif

// ===== design/sph_pkg.sv =====
// Package with the SipHash stream types, constants and round function.
`default_nettype none
package sph_pkg;

    // Start constants of the four lanes.
    localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
    localparam logic [63:0] FINAL_MARK = 64'h00000000000000ff;

    // Input mode codes.
    localparam logic [1:0] MODE_ABSORB       = 2'd0;
    localparam logic [1:0] MODE_ABSORB_FINAL = 2'd1;
    localparam logic [1:0] MODE_FINAL        = 2'd2;

    // Configuration register indexes.
    localparam int          CFG_IDX_W    = 2;
    localparam logic [1:0]  REG_KEY_LOW  = 2'd0;
    localparam logic [1:0]  REG_KEY_HIGH = 2'd1;

    // Default depth of the word queue.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Kind of work handed from the packer to the round engine.
    typedef enum logic [1:0] {
        KIND_WORD,
        KIND_FINAL,
        KIND_WORD_FINAL
    } t_kind;

    // One queue entry: a word to absorb, plus the length byte for finalization.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  len;
        logic [63:0] word;
    } t_entry;

    // Queue status seen by the producer and the consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Configuration write as seen inside the block.
    typedef struct packed {
        logic                 en;
        logic [CFG_IDX_W-1:0] index;
        logic [63:0]          data;
    } t_cfg_wr;

    typedef logic [3:0][63:0] t_lanes;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ABSORB,
        BK_FINAL
    } t_back_state;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
        rotl64 = (x << r) | (x >> (64 - r));
    endfunction

    // One SipRound over the four lanes.
    function automatic t_lanes sip_round(input t_lanes v);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
        a = v[0];
        b = v[1];
        c = v[2];
        d = v[3];
        a = a + b; b = rotl64(b, 13); b = b ^ a; a = rotl64(a, 32);
        c = c + d; d = rotl64(d, 16); d = d ^ c;
        a = a + d; d = rotl64(d, 21); d = d ^ a;
        c = c + b; b = rotl64(b, 17); b = b ^ c; c = rotl64(c, 32);
        sip_round = {d, c, b, a};
    endfunction

    // Start state of the lanes for a given key.
    function automatic t_lanes start_lanes(input logic [63:0] k0, input logic [63:0] k1);
        start_lanes = {SIP_C3 ^ k1, SIP_C2 ^ k0, SIP_C1 ^ k1, SIP_C0 ^ k0};
    endfunction

endpackage
`default_nettype wire

// ===== design/sph_channels.sv =====
// Handshake channel interfaces of the SipHash stream block.
`default_nettype none

// Message byte channel.
interface sph_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [1:0] mode;
    modport source (output valid, output data_byte, output mode, input ready);
    modport sink   (input valid, input data_byte, input mode, output ready);
endinterface

// Digest channel.
interface sph_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest;
    modport source (output valid, output digest, input ready);
    modport sink   (input valid, input digest, output ready);
endinterface

// Configuration write channel.
interface sph_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/sph_front.sv =====
// Byte packer: gathers bytes into words and queues absorb and finalize work.
`default_nettype none
module sph_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic [1:0]      i_mode,
    output logic                 o_ready,
    input  wire sph_pkg::t_cfg_wr   i_cfg,
    input  wire sph_pkg::t_q_status i_q_status,
    output logic                 o_push,
    output sph_pkg::t_entry      o_entry
);
    import sph_pkg::*;

    logic [55:0] r_pend, n_pend;
    logic [2:0]  r_cnt, n_cnt;
    logic [7:0]  r_len, n_len;
    logic [55:0] w_ins;
    logic [7:0]  w_len_inc;
    logic        w_accept;
    logic        w_clear;

    assign o_ready   = !i_q_status.full;
    assign w_accept  = i_valid && o_ready;
    assign w_len_inc = r_len + 8'd1;
    assign w_clear   = i_cfg.en && (i_cfg.index == REG_KEY_LOW || i_cfg.index == REG_KEY_HIGH);

    // Pending bytes with the new byte placed at the next free lane.
    always_comb begin
        w_ins = r_pend;
        for (int k = 0; k < 7; k++) begin
            if (r_cnt == 3'(k)) begin
                w_ins[8*k +: 8] = i_data_byte;
            end
        end
    end

    // Mode decode and queue entry build.
    always_comb begin
        n_pend  = r_pend;
        n_cnt   = r_cnt;
        n_len   = r_len;
        o_push  = 1'b0;
        o_entry = '{kind: KIND_WORD, len: w_len_inc, word: {i_data_byte, r_pend}};
        if (w_accept) begin
            unique case (i_mode)
                MODE_ABSORB: begin
                    n_len = w_len_inc;
                    if (r_cnt == 3'd7) begin
                        o_push = 1'b1;
                        n_pend = '0;
                        n_cnt  = '0;
                    end else begin
                        n_pend = w_ins;
                        n_cnt  = r_cnt + 3'd1;
                    end
                end
                MODE_ABSORB_FINAL: begin
                    o_push = 1'b1;
                    if (r_cnt == 3'd7) begin
                        o_entry.kind = KIND_WORD_FINAL;
                    end else begin
                        o_entry.kind = KIND_FINAL;
                        o_entry.word = {w_len_inc, w_ins};
                    end
                    n_pend = '0;
                    n_cnt  = '0;
                    n_len  = '0;
                end
                MODE_FINAL: begin
                    o_push       = 1'b1;
                    o_entry.kind = KIND_FINAL;
                    o_entry.len  = r_len;
                    o_entry.word = {r_len, r_pend};
                    n_pend = '0;
                    n_cnt  = '0;
                    n_len  = '0;
                end
                default: begin
                    // Unused mode: the byte is taken and dropped.
                end
            endcase
        end
        if (w_clear) begin
            n_pend = '0;
            n_cnt  = '0;
            n_len  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
            r_len  <= '0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
            r_len  <= n_len;
        end
    end

endmodule
`default_nettype wire

// ===== design/sph_queue.sv =====
// Small first-in first-out queue of words between the packer and the round engine.
`default_nettype none
`include "siphash_2_4_stream_assert.svh"
module sph_queue #(
    parameter int DEPTH = sph_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire sph_pkg::t_entry i_entry,
    input  wire logic            i_pop,
    output sph_pkg::t_entry      o_head,
    output sph_pkg::t_q_status   o_status
);
    import sph_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push;
    logic             w_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_head = r_mem[r_rd];

    // Pointer and fill count update.
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    `SPH_NEVER(a_count_bound, r_count > CNT_W'(DEPTH), "queue fill count above depth")
    `SPH_ASSERT(a_ptr_gap, (o_status.empty && r_wr != r_rd) == 1'b0, "pointers differ on empty queue")

endmodule
`default_nettype wire

// ===== design/sph_back.sv =====
// Round engine: runs SipRounds on queued words and delivers the digest.
`default_nettype none
`include "siphash_2_4_stream_assert.svh"
module sph_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sph_pkg::t_cfg_wr  i_cfg,
    input  wire sph_pkg::t_entry   i_head,
    input  wire sph_pkg::t_q_status i_q_status,
    output logic                   o_pop,
    output logic                   o_valid,
    output logic [63:0]            o_digest,
    input  wire logic              i_ready
);
    import sph_pkg::*;

    t_back_state r_state, n_state;
    t_lanes      r_lanes, n_lanes;
    logic [63:0] r_key_low, n_key_low;
    logic [63:0] r_key_high, n_key_high;
    logic [63:0] r_word, n_word;
    t_kind       r_kind, n_kind;
    logic [7:0]  r_len, n_len;
    logic [1:0]  r_cnt, n_cnt;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_digest, n_digest;
    t_lanes      w_round;
    logic        w_out_free;

    assign w_round    = sip_round(r_lanes);
    assign w_out_free = !r_out_valid || i_ready;
    assign o_valid    = r_out_valid;
    assign o_digest   = r_digest;

    // Sequencer over absorb and finalization rounds.
    always_comb begin
        n_state     = r_state;
        n_lanes     = r_lanes;
        n_key_low   = r_key_low;
        n_key_high  = r_key_high;
        n_word      = r_word;
        n_kind      = r_kind;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_digest    = r_digest;
        o_pop       = 1'b0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop      = 1'b1;
                    n_lanes[3] = r_lanes[3] ^ i_head.word;
                    n_word     = i_head.word;
                    n_kind     = i_head.kind;
                    n_len      = i_head.len;
                    n_cnt      = '0;
                    n_state    = BK_ABSORB;
                end
            end
            BK_ABSORB: begin
                n_lanes = w_round;
                n_cnt   = r_cnt + 2'd1;
                if (r_cnt == 2'd1) begin
                    n_lanes[0] = w_round[0] ^ r_word;
                    n_cnt      = '0;
                    case (r_kind)
                        KIND_WORD: begin
                            n_state = BK_IDLE;
                        end
                        KIND_WORD_FINAL: begin
                            // The full word is in; the length word follows.
                            n_word     = {r_len, 56'h0};
                            n_lanes[3] = w_round[3] ^ {r_len, 56'h0};
                            n_kind     = KIND_FINAL;
                        end
                        default: begin
                            n_lanes[2] = w_round[2] ^ FINAL_MARK;
                            n_state    = BK_FINAL;
                        end
                    endcase
                end
            end
            BK_FINAL: begin
                if (r_cnt != 2'd3) begin
                    n_lanes = w_round;
                    n_cnt   = r_cnt + 2'd1;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_digest    = w_round[0] ^ w_round[1] ^ w_round[2] ^ w_round[3];
                    n_lanes     = start_lanes(r_key_low, r_key_high);
                    n_cnt       = '0;
                    n_state     = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
        // A key write reloads the start state.
        if (i_cfg.en && i_cfg.index == REG_KEY_LOW) begin
            n_key_low = i_cfg.data;
            n_lanes   = start_lanes(i_cfg.data, r_key_high);
        end else if (i_cfg.en && i_cfg.index == REG_KEY_HIGH) begin
            n_key_high = i_cfg.data;
            n_lanes    = start_lanes(r_key_low, i_cfg.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_lanes     <= start_lanes(64'h0, 64'h0);
            r_key_low   <= '0;
            r_key_high  <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lanes     <= n_lanes;
            r_key_low   <= n_key_low;
            r_key_high  <= n_key_high;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_kind   <= n_kind;
        r_len    <= n_len;
        r_digest <= n_digest;
    end

    `SPH_NEVER(a_pop_idle, o_pop && r_state != BK_IDLE, "queue popped while rounds are running")
    `SPH_ASSERT(a_final_wait, (r_state == BK_FINAL && r_cnt == 2'd3 && !w_out_free) |=> (r_state == BK_FINAL), "digest dropped while output is stalled")

endmodule
`default_nettype wire

// ===== design/siphash_2_4_stream.sv =====
// Top level of the keyed SipHash-2-4 byte stream hasher.
//
//  Channel   Dir   Payload              Handshake
//  i_in      in    data_byte, mode      valid/ready
//  o_out     out   digest               valid/ready
//  i_cfg     in    index, data          valid/ready (ready always high)
//
// The packer takes one byte per cycle; every eighth byte queues a word.
// The round engine runs one SipRound per cycle, pops a word only when idle
// and gives it two rounds; finalization adds four after the length word.
// Bytes stall only when the word queue is full; the digest waits in an
// output register, and finalization holds its last round until it is free.
// Reset loads the lanes from an all-zero key and clears the queue.
`default_nettype none
module siphash_2_4_stream #(
    parameter int QUEUE_DEPTH = sph_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sph_in_if.sink     i_in,
    sph_out_if.source  o_out,
    sph_cfg_if.sink    i_cfg
);
    import sph_pkg::*;

    t_cfg_wr   w_cfg;
    t_entry    w_push_entry;
    t_entry    w_head;
    t_q_status w_q_status;
    logic      w_push;
    logic      w_pop;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;
    assign w_cfg.en    = i_cfg.valid;
    assign w_cfg.index = i_cfg.index;
    assign w_cfg.data  = i_cfg.data;

    sph_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_data_byte (i_in.data_byte),
        .i_mode      (i_in.mode),
        .o_ready     (i_in.ready),
        .i_cfg       (w_cfg),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_entry     (w_push_entry)
    );

    sph_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_push_entry),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    sph_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_head     (w_head),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_valid    (o_out.valid),
        .o_digest   (o_out.digest),
        .i_ready    (o_out.ready)
    );

endmodule
`default_nettype wire
